/* rtl/core/sorted_min_priority_queue_assert.svh */
// assertion macros used by the queue rtl
`ifndef SORTED_MIN_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_MIN_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, checked on every rising clk edge outside reset
`define SMPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("queue assertion failed");

// next-cycle implication, checked on every rising clk edge outside reset
`define SMPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("queue assertion failed");

`endif

/* rtl/core/smpq_pkg.sv */
package smpq_pkg;

  // field widths
  localparam int ID_W          = 24;
  localparam int KEY_W         = 16;
  localparam int STATUS_W      = 2;
  localparam int ENTRY_COUNT_W = 7;

  // default number of cells
  localparam int DEPTH_DEFAULT = 64;

  // request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_POP    = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_INS_FULL  = 2'd2;

  // one held entry
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
  } smpq_entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic        ins;
    logic        pop;
    smpq_entry_t entry;
  } smpq_ctrl_t;

  // input word
  typedef struct packed {
    logic             req_type;
    logic [ID_W-1:0]  node_id;
    logic [KEY_W-1:0] node_len;
  } in_item_t;

  // output word
  typedef struct packed {
    logic [ID_W-1:0]          out_id;
    logic [KEY_W-1:0]         out_len;
    logic [STATUS_W-1:0]      status;
    logic [ENTRY_COUNT_W-1:0] entry_count;
    logic                     queue_empty;
  } out_item_t;

endpackage

/* rtl/core/sorted_min_priority_queue.sv */
// latency: a request's result word is valid in the cycle after it is accepted
// throughput: one request per cycle while the output word is not held; all cells compare and shift in parallel
// the cell row holds DEPTH entries; count and output valid clear on reset
// cell contents are not cleared on reset and are only read below the count
module sorted_min_priority_queue #(
  parameter int DEPTH = smpq_pkg::DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  smpq_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output smpq_pkg::out_item_t out_item
);
  import smpq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          in_acc;
  logic          is_pop;
  logic          full;
  logic          empty;
  logic          do_ins;
  logic          do_pop;
  smpq_ctrl_t    ctrl;
  smpq_entry_t   new_entry;
  out_item_t     out_item_next;

  logic        cell_le    [DEPTH];
  logic        cell_occ   [DEPTH];
  smpq_entry_t cell_entry [DEPTH];

  // handshake: a new word is taken unless the output word is held
  assign in_stall = out_valid && out_stall;
  assign in_acc   = in_valid && !in_stall;

  // request decode
  always_comb begin
    is_pop    = (in_item.req_type == REQ_POP);
    full      = (count == CW'(DEPTH));
    empty     = (count == '0);
    do_ins    = in_acc && !is_pop && !full;
    do_pop    = in_acc && is_pop && !empty;
    new_entry = '{id: in_item.node_id, key: in_item.node_len};
    ctrl      = '{ins: do_ins, pop: do_pop, entry: new_entry};
  end

  // count update
  always_comb begin
    count_next = count;
    if (do_ins) begin
      count_next = count + CW'(1);
    end else if (do_pop) begin
      count_next = count - CW'(1);
    end
  end

  // result word
  always_comb begin
    out_item_next.out_id      = do_pop ? cell_entry[0].id : '0;
    out_item_next.out_len     = do_pop ? cell_entry[0].key : '0;
    out_item_next.status      = STATUS_OK;
    if (in_acc && is_pop && empty) begin
      out_item_next.status = STATUS_POP_EMPTY;
    end else if (in_acc && !is_pop && full) begin
      out_item_next.status = STATUS_INS_FULL;
    end
    out_item_next.entry_count = ENTRY_COUNT_W'(count_next);
    out_item_next.queue_empty = (count_next == '0);
  end

  // row of cells, sorted ascending from cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic        left_le;
    smpq_entry_t left_entry;
    smpq_entry_t right_entry;

    assign cell_occ[i] = (CW'(i) < count);

    if (i == 0) begin : g_head
      assign left_le    = 1'b1;
      assign left_entry = new_entry;
    end else begin : g_body
      assign left_le    = cell_le[i-1];
      assign left_entry = cell_entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    smpq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (cell_occ[i]),
      .left_le    (left_le),
      .left_entry (left_entry),
      .right_entry(right_entry),
      .le         (cell_le[i]),
      .entry      (cell_entry[i])
    );
  end

  // count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (in_acc) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_item <= out_item_next;
    end
  end

  `include "sorted_min_priority_queue_assert.svh"

  `SMPQ_ASSERT_NOW(a_count_range, 1'b1, count <= CW'(DEPTH))
  `SMPQ_ASSERT_NOW(a_head_sorted, cell_occ[1], cell_entry[0].key <= cell_entry[1].key)
  `SMPQ_ASSERT_NEXT(a_ins_count, do_ins, count == $past(count) + CW'(1))
  `SMPQ_ASSERT_NEXT(a_pop_count, do_pop, count == $past(count) - CW'(1))
  `SMPQ_ASSERT_NEXT(a_result_shown, in_acc, out_valid)

endmodule

/* rtl/core/smpq_cell.sv */
module smpq_cell (
  input  logic               clk,
  input  smpq_pkg::smpq_ctrl_t  ctrl,
  input  logic               occupied,
  input  logic               left_le,
  input  smpq_pkg::smpq_entry_t left_entry,
  input  smpq_pkg::smpq_entry_t right_entry,
  output logic               le,
  output smpq_pkg::smpq_entry_t entry
);
  import smpq_pkg::*;

  // held key is at or below the new key, so this cell stays put on insert
  always_comb begin
    le = occupied && (entry.key <= ctrl.entry.key);
  end

  // insert: keep, take the new entry, or shift up from the left neighbor
  // pop: shift down from the right neighbor
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (!le) begin
        entry <= left_le ? ctrl.entry : left_entry;
      end
    end else if (ctrl.pop) begin
      entry <= right_entry;
    end
  end

endmodule

/* sim/sorted_min_priority_queue_tb.sv */
module sorted_min_priority_queue_tb;
  import smpq_pkg::*;

  localparam int DEPTH        = DEPTH_DEFAULT;
  localparam int RANDOM_WORDS = 1230;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 8;
  localparam int GAP_MAX      = 6;

  typedef struct {
    in_item_t word;
    bit       drain_first;
  } pending_word_t;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  // handshakes seen at the last rising edge
  logic in_took;
  logic out_took;

  pending_word_t pending_words[$];
  pending_word_t head_word;
  out_item_t     awaited_words[$];
  smpq_entry_t   held_entries[$];

  int fail_count;
  int idle_cycles;
  int send_wait;
  int send_gap_max;
  int stall_left;
  int recv_stall_max;

  sorted_min_priority_queue #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // sorted queue predictor: insert after equal keys, pop from the head
  function automatic out_item_t serve_request(in_item_t req);
    out_item_t   res;
    smpq_entry_t ent;
    int          pos;
    res = '0;
    res.status = STATUS_OK;
    if (req.req_type == REQ_INSERT) begin
      if (held_entries.size() >= DEPTH) begin
        res.status = STATUS_INS_FULL;
      end else begin
        pos = held_entries.size();
        while (pos > 0 && req.node_len < held_entries[pos-1].key) pos--;
        ent.id  = req.node_id;
        ent.key = req.node_len;
        held_entries.insert(pos, ent);
      end
    end else begin
      if (held_entries.size() == 0) begin
        res.status = STATUS_POP_EMPTY;
      end else begin
        ent = held_entries.pop_front();
        res.out_id  = ent.id;
        res.out_len = ent.key;
      end
    end
    res.entry_count = ENTRY_COUNT_W'(held_entries.size());
    res.queue_empty = (held_entries.size() == 0);
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // compare one result word against the oldest expectation
  task automatic check_word(out_item_t got);
    out_item_t want;
    if (awaited_words.size() == 0) begin
      $display("%0t: unexpected result word, expected none, actual %p", $time, got);
      fail_count++;
    end else begin
      want = awaited_words.pop_front();
      check_field("out_id", 32'(want.out_id), 32'(got.out_id));
      check_field("out_len", 32'(want.out_len), 32'(got.out_len));
      check_field("status", 32'(want.status), 32'(got.status));
      check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
      check_field("queue_empty", 32'(want.queue_empty), 32'(got.queue_empty));
    end
  endtask

  task automatic queue_request(logic req, logic [ID_W-1:0] id, logic [KEY_W-1:0] key,
                               bit drain_first);
    pending_word_t w;
    w.word.req_type = req;
    w.word.node_id  = id;
    w.word.node_len = key;
    w.drain_first   = drain_first;
    pending_words.push_back(w);
  endtask

  // keys: full range half the time, else a narrow range so ties are common, or an extreme
  function automatic logic [KEY_W-1:0] draw_key();
    case ($urandom_range(0, 5))
      0, 1:    return KEY_W'($urandom_range(0, 7));
      2:       return $urandom_range(0, 1) ? '1 : '0;
      default: return KEY_W'($urandom());
    endcase
  endfunction

  // monitor, predictor and watchdog on the rising edge
  always @(posedge clk) begin
    if (rst) begin
      in_took     <= 1'b0;
      out_took    <= 1'b0;
      idle_cycles = 0;
    end else begin
      in_took  <= in_valid && !in_stall;
      out_took <= out_valid && !out_stall;
      if (out_valid && !out_stall) check_word(out_item);
      if (in_valid && !in_stall) awaited_words.push_back(serve_request(in_item));
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("sorted_min_priority_queue test failed");
          $finish;
        end
      end
    end
  end

  // input driver: one word at a time, random gap after each accepted word
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_took) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0 &&
                     !(pending_words[0].drain_first && awaited_words.size() != 0)) begin
          head_word = pending_words.pop_front();
          in_item  <= head_word.word;
          in_valid <= 1'b1;
          if ($urandom_range(0, 39) == 0) send_gap_max = send_gap_max ? 0 : GAP_MAX;
          send_wait = $urandom_range(0, send_gap_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output stall: random hold after each accepted word
  always @(negedge clk) begin
    if (!rst) begin
      if (out_took) begin
        if ($urandom_range(0, 39) == 0) recv_stall_max = recv_stall_max ? 0 : GAP_MAX;
        stall_left = $urandom_range(0, recv_stall_max);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int   issued;
    int   phase_len;
    int   insert_pct;
    logic req;
    bit   first_phase;

    clk            = 1'b0;
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_item        = '0;
    out_stall      = 1'b0;
    fail_count     = 0;
    send_wait      = 0;
    send_gap_max   = GAP_MAX;
    stall_left     = 0;
    recv_stall_max = GAP_MAX;

    // directed: empty pop, extreme ids and keys, ties at both ends, drain
    queue_request(REQ_POP, '1, '1, 1'b0);
    queue_request(REQ_INSERT, '1, '1, 1'b0);
    queue_request(REQ_INSERT, '0, '0, 1'b0);
    queue_request(REQ_INSERT, 24'h5A5A5A, 16'h8000, 1'b0);
    queue_request(REQ_INSERT, 24'hA5A5A5, 16'h8000, 1'b0);
    queue_request(REQ_INSERT, 24'h000001, 16'h0000, 1'b0);
    queue_request(REQ_INSERT, 24'h000002, 16'hFFFF, 1'b0);
    queue_request(REQ_INSERT, 24'h800000, 16'h7FFF, 1'b0);
    repeat (7) queue_request(REQ_POP, ID_W'($urandom()), KEY_W'($urandom()), 1'b0);
    queue_request(REQ_POP, '0, '0, 1'b0);
    queue_request(REQ_INSERT, 24'h123456, 16'h0001, 1'b0);
    queue_request(REQ_POP, '0, '0, 1'b0);

    // random phases: fill-heavy, drain-heavy and balanced mixes
    issued      = 0;
    first_phase = 1'b1;
    while (issued < RANDOM_WORDS) begin
      phase_len = first_phase ? 140 : $urandom_range(20, 120);
      case ($urandom_range(0, 2))
        0:       insert_pct = 90;
        1:       insert_pct = 10;
        default: insert_pct = 50;
      endcase
      if (first_phase) insert_pct = 90;
      for (int k = 0; k < phase_len; k++) begin
        req = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_POP;
        queue_request(req, ID_W'($urandom()), draw_key(), issued == 600);
        issued++;
      end
      first_phase = 1'b0;
    end

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // wait for all words sent and all results back, then a short tail
    while (pending_words.size() != 0 || in_valid) @(negedge clk);
    while (awaited_words.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (fail_count == 0 && awaited_words.size() == 0) begin
      $display("sorted_min_priority_queue test passed");
    end else begin
      $display("sorted_min_priority_queue test failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/smpq_pkg.sv
rtl/core/smpq_cell.sv
rtl/core/sorted_min_priority_queue.sv
sim/sorted_min_priority_queue_tb.sv
